[hdl/bdc_pkg.sv]
package bdc_pkg;

    localparam int MAX_DEGREE_DEF = 7;
    localparam logic [2:0] DEGREE_RESET = 3'd3;
    localparam logic [16:0] T_ONE = 17'h10000;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_EVAL  = 2'd1;
    localparam logic [1:0] OP_SPLIT = 2'd2;

    localparam logic [1:0] KIND_EVAL   = 2'd0;
    localparam logic [1:0] KIND_FIRST  = 2'd1;
    localparam logic [1:0] KIND_SECOND = 2'd2;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_point;

    typedef struct packed {
        logic        valid;
        logic [1:0]  op;
        logic [2:0]  idx;
        t_point      pt;
        logic [16:0] t;
    } t_cmd;

    // (b - a) * t, full precision
    function automatic logic signed [34:0] f_scale(logic signed [15:0] a,
                                                   logic signed [15:0] b,
                                                   logic [16:0] t);
        logic signed [16:0] diff;
        logic signed [17:0] ts;
        logic signed [34:0] prod;
        diff = $signed({b[15], b}) - $signed({a[15], a});
        ts   = $signed({1'b0, t});
        prod = 35'(diff) * 35'(ts);
        return prod;
    endfunction

endpackage

[hdl/bezier_de_casteljau_eval_split.sv]
// de casteljau evaluation and subdivision of one 3d bezier curve
// s_axis carries one item: tuser is the opcode (write point, evaluate, split),
// tdata holds point_index, coord_x, coord_y, coord_z and t_fraction.
// a write item stores a control point and gives no result.
// evaluate returns one point (tuser kind 0, tlast high); split returns the
// d+1 first-half points then the d+1 second-half points, tlast on the last.
// the interpolation triangle walks rows r = 0..d, reading the row from the
// point memory one entry a cycle through a two-stage interpolator, then
// waiting for the writes to land.
// split results stream at one per cycle while m_axis is ready.
// sequential: s_axis_tready is high only while no item is in work.
// a final result held in the output register does not block the next item.
// i_cfg_we writes curve_degree (reset 3) and is only used while idle.
// reset clears control state; point memories are undefined until written.
// a stalled receiver holds the output register and emission waits for it.
module bezier_de_casteljau_eval_split #(
    parameter int MAX_DEGREE = bdc_pkg::MAX_DEGREE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // point_index, coord_x, coord_y, coord_z, t_fraction
    input  logic [1:0]  i_s_axis_tuser,   // opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // out_index, out_x, out_y, out_z
    output logic [1:0]  o_m_axis_tuser,   // result_kind
    output logic        o_m_axis_tlast    // last_of_run
);

    logic [2:0]      r_degree;
    bdc_pkg::t_cmd   w_cmd;
    logic            w_idle;
    logic [16:0]     w_t_raw;
    logic [2:0]      w_oidx;
    bdc_pkg::t_point w_opt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= bdc_pkg::DEGREE_RESET;
        end else if (i_cfg_we) begin
            r_degree <= i_cfg_wdata;
        end
    end

    assign o_s_axis_tready = w_idle;
    assign w_t_raw = i_s_axis_tdata[67:51];

    always_comb begin
        w_cmd.valid = i_s_axis_tvalid & w_idle;
        w_cmd.op    = i_s_axis_tuser;
        w_cmd.idx   = i_s_axis_tdata[2:0];
        w_cmd.pt.x  = i_s_axis_tdata[18:3];
        w_cmd.pt.y  = i_s_axis_tdata[34:19];
        w_cmd.pt.z  = i_s_axis_tdata[50:35];
        w_cmd.t     = (w_t_raw > bdc_pkg::T_ONE) ? bdc_pkg::T_ONE : w_t_raw;
    end

    bdc_core #(.MAX_DEGREE(MAX_DEGREE)) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_degree (r_degree),
        .o_idle   (w_idle),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_kind   (o_m_axis_tuser),
        .o_index  (w_oidx),
        .o_point  (w_opt),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {5'd0, w_opt.z, w_opt.y, w_opt.x, w_oidx};

endmodule

[hdl/bdc_lerp.sv]
module bdc_lerp #(
    parameter int SW = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  bdc_pkg::t_point i_a,
    input  bdc_pkg::t_point i_b,
    input  logic [16:0]     i_t,
    input  logic [SW-1:0]   i_dest,
    output logic            o_valid,
    output bdc_pkg::t_point o_point,
    output logic [SW-1:0]   o_dest,
    output logic            o_busy
);

    logic                   r_v1;
    logic                   r_v2;
    bdc_pkg::t_point        r_a;
    logic signed [34:0]     r_px;
    logic signed [34:0]     r_py;
    logic signed [34:0]     r_pz;
    logic [SW-1:0]          r_d1;
    logic [SW-1:0]          r_d2;
    bdc_pkg::t_point        r_res;
    logic signed [34:0]     w_qx;
    logic signed [34:0]     w_qy;
    logic signed [34:0]     w_qz;

    // arithmetic shift gives the floor
    assign w_qx = r_px >>> 16;
    assign w_qy = r_py >>> 16;
    assign w_qz = r_pz >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_a   <= i_a;
        r_px  <= bdc_pkg::f_scale(i_a.x, i_b.x, i_t);
        r_py  <= bdc_pkg::f_scale(i_a.y, i_b.y, i_t);
        r_pz  <= bdc_pkg::f_scale(i_a.z, i_b.z, i_t);
        r_d1  <= i_dest;
        r_d2  <= r_d1;
        r_res.x <= r_a.x + w_qx[15:0];
        r_res.y <= r_a.y + w_qy[15:0];
        r_res.z <= r_a.z + w_qz[15:0];
    end

    assign o_valid = r_v2;
    assign o_point = r_res;
    assign o_dest  = r_d2;
    assign o_busy  = r_v1 | r_v2;

endmodule

[hdl/bdc_core.sv]
module bdc_core #(
    parameter int MAX_DEGREE = bdc_pkg::MAX_DEGREE_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bdc_pkg::t_cmd   i_cmd,
    input  logic [2:0]      i_degree,
    output logic            o_idle,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [1:0]      o_kind,
    output logic [2:0]      o_index,
    output bdc_pkg::t_point o_point,
    output logic            o_last
);

    localparam int SLOTS = MAX_DEGREE + 1;
    localparam int SW = $clog2(SLOTS);

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_DRAIN, S_EMIT} t_state;

    t_state          r_state;
    bdc_pkg::t_point r_ctrl_mem [SLOTS];
    bdc_pkg::t_point r_work_mem [SLOTS];
    bdc_pkg::t_point r_first_mem [SLOTS];
    bdc_pkg::t_point r_second_mem [SLOTS];
    bdc_pkg::t_point r_ctrl_q;
    bdc_pkg::t_point r_work_q;
    bdc_pkg::t_point r_prev;
    bdc_pkg::t_point w_cur;
    logic [1:0]      r_op;
    logic [16:0]     r_t;
    logic [SW-1:0]   r_deg;
    logic [SW-1:0]   r_row;
    logic [SW-1:0]   r_k;
    logic [SW-1:0]   r_rk;
    logic            r_rv;
    logic            r_half;
    logic [SW-1:0]   r_e_idx;
    logic            r_ovalid;
    logic [1:0]      r_okind;
    logic [2:0]      r_oidx;
    bdc_pkg::t_point r_opt;
    logic            r_olast;
    logic [SW-1:0]   w_deg;
    logic [SW-1:0]   w_row_last;
    logic            w_l_valid;
    logic            w_lo_valid;
    bdc_pkg::t_point w_lo_point;
    logic [SW-1:0]   w_lo_dest;
    logic            w_l_busy;
    logic            w_load;

    always_comb begin
        if (32'(i_degree) > MAX_DEGREE) begin
            w_deg = SW'(MAX_DEGREE);
        end else begin
            w_deg = SW'(i_degree);
        end
    end

    assign w_row_last = r_deg - r_row;
    assign w_cur = (r_row == '0) ? r_ctrl_q : r_work_q;
    assign w_l_valid = r_rv && (r_rk != '0) && (r_row != r_deg);
    assign w_load = (r_state == S_EMIT) && (!r_ovalid || i_tready);

    bdc_lerp #(.SW(SW)) u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_l_valid),
        .i_a     (r_prev),
        .i_b     (w_cur),
        .i_t     (r_t),
        .i_dest  (r_rk - SW'(1)),
        .o_valid (w_lo_valid),
        .o_point (w_lo_point),
        .o_dest  (w_lo_dest),
        .o_busy  (w_l_busy)
    );

    // point stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.op == bdc_pkg::OP_WRITE && 32'(i_cmd.idx) < SLOTS) begin
            r_ctrl_mem[SW'(i_cmd.idx)] <= i_cmd.pt;
        end
        r_ctrl_q <= r_ctrl_mem[r_k];
        r_work_q <= r_work_mem[r_k];
        if (w_lo_valid) begin
            r_work_mem[w_lo_dest] <= w_lo_point;
        end
        if (r_rv) begin
            r_prev <= w_cur;
            if (r_rk == '0) begin
                r_first_mem[r_row] <= w_cur;
            end
            if (r_rk == w_row_last) begin
                r_second_mem[r_rk] <= w_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_rv <= (r_state == S_ISSUE);
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid && (i_cmd.op == bdc_pkg::OP_EVAL ||
                                        i_cmd.op == bdc_pkg::OP_SPLIT)) begin
                        r_op    <= i_cmd.op;
                        r_t     <= i_cmd.t;
                        r_deg   <= w_deg;
                        r_row   <= '0;
                        r_k     <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_rk <= r_k;
                    if (r_k == w_row_last) begin
                        r_k     <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + SW'(1);
                    end
                end
                S_DRAIN: begin
                    if (!r_rv && !w_l_busy) begin
                        if (r_row == r_deg) begin
                            r_half  <= 1'b0;
                            r_e_idx <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_row   <= r_row + SW'(1);
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        if (r_op == bdc_pkg::OP_EVAL) begin
                            r_okind <= bdc_pkg::KIND_EVAL;
                            r_oidx  <= 3'd0;
                            r_opt   <= r_first_mem[r_deg];
                            r_olast <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (!r_half) begin
                            r_okind <= bdc_pkg::KIND_FIRST;
                            r_oidx  <= 3'(r_e_idx);
                            r_opt   <= r_first_mem[r_e_idx];
                            r_olast <= 1'b0;
                            if (r_e_idx == r_deg) begin
                                r_half  <= 1'b1;
                                r_e_idx <= '0;
                            end else begin
                                r_e_idx <= r_e_idx + SW'(1);
                            end
                        end else begin
                            r_okind <= bdc_pkg::KIND_SECOND;
                            r_oidx  <= 3'(r_e_idx);
                            r_opt   <= r_second_mem[r_e_idx];
                            r_olast <= (r_e_idx == r_deg);
                            if (r_e_idx == r_deg) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_e_idx <= r_e_idx + SW'(1);
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle   = (r_state == S_IDLE);
    assign o_tvalid = r_ovalid;
    assign o_kind   = r_okind;
    assign o_index  = r_oidx;
    assign o_point  = r_opt;
    assign o_last   = r_olast;

    a_emit_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (!r_rv && !w_l_busy))
        else $error("emit while interpolation pending");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE || r_state == S_DRAIN) |-> (r_row <= r_deg))
        else $error("row beyond degree");

    a_cmd_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid |-> (r_state == S_IDLE))
        else $error("command while busy");

    a_write_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lo_valid |-> (w_lo_dest < r_deg))
        else $error("work write out of range");

endmodule
